/* hw/rtl/c2s_pkg.sv */
// c2s_pkg: shared constants, arctangent table and gain helper for the
// cartesian to spherical converter; used by the interfaces and the top level
package c2s_pkg;

  localparam int COORD_BITS_DEF = 32;
  localparam int ANGLE_BITS_DEF = 16;

  // vectoring iterations per angle, datapath and angle accumulator widths
  localparam int CORDIC_ITERS = 32;
  localparam int CORDIC_W     = 64;
  localparam int ACC_W        = 34;

  // internal angle format is 2^32 per turn
  localparam logic signed [ACC_W-1:0] QTR_TURN  = 34'sd1073741824;
  localparam logic signed [ACC_W-1:0] HALF_TURN = 34'sd2147483648;

  // cordic gain in q30
  localparam logic [63:0] GAIN_Q30 = 64'd1768195363;

  // round(atan(2^-i) / (2 pi) * 2^32)
  localparam logic [31:0] ATAN_TAB [CORDIC_ITERS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,
    32'd41,        32'd20,        32'd10,        32'd5,
    32'd3,         32'd1,         32'd1,         32'd0
  };

  // gain scaled to the prescaled coordinate format, rounded
  function automatic logic [63:0] gain_scaled(input int prescale);
    logic [63:0] g;
    g = GAIN_Q30;
    if (prescale >= 30) begin
      return g << (prescale - 30);
    end
    return (g + (64'd1 << (29 - prescale))) >> (30 - prescale);
  endfunction

endpackage

/* hw/rtl/c2s_in_if.sv */
// c2s_in_if: valid/ready channel carrying one rectangular point word
// depends on c2s_pkg for the default coordinate width
interface c2s_in_if #(
  parameter int COORD_BITS = c2s_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] coord_x;
  logic signed [COORD_BITS-1:0] coord_y;
  logic signed [COORD_BITS-1:0] coord_z;

  modport source (output valid, output coord_x, output coord_y, output coord_z,
                  input ready);
  modport sink   (input valid, input coord_x, input coord_y, input coord_z,
                  output ready);
endinterface

/* hw/rtl/c2s_out_if.sv */
// c2s_out_if: valid/ready channel carrying one range, azimuth, elevation word
// depends on c2s_pkg for the default widths
interface c2s_out_if #(
  parameter int COORD_BITS = c2s_pkg::COORD_BITS_DEF,
  parameter int ANGLE_BITS = c2s_pkg::ANGLE_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic        [COORD_BITS-1:0] slant_range;
  logic signed [ANGLE_BITS-1:0] azimuth;
  logic signed [ANGLE_BITS-1:0] elevation;
  logic                         origin_flag;

  modport source (output valid, output slant_range, output azimuth,
                  output elevation, output origin_flag, input ready);
  modport sink   (input valid, input slant_range, input azimuth,
                  input elevation, input origin_flag, output ready);
endinterface

/* hw/rtl/cartesian_to_spherical.sv */
// cartesian_to_spherical: pipelined rectangular to range/azimuth/elevation
// converter; depends on c2s_pkg, c2s_in_if and c2s_out_if
//
// in_ch takes one point word (coord_x, coord_y, coord_z) at each edge where
// valid and ready are both high; out_ch gives one word per point, in order:
// slant_range (rounded euclidean distance), azimuth (from +y toward +x),
// elevation, both with 2^ANGLE_BITS counts per turn, and origin_flag for the
// zero vector, where both angles are zero.
// throughput is one point per clock while the skid register is empty; a point
// goes from the accepting edge to out_ch through one stage of squaring and gain
// multiply, one summing stage, 64 unrolled vectoring stages (32 for azimuth,
// then 32 for elevation, the integer square root running one bit per stage
// alongside the first of them), one rounding stage and the output register.
// a synchronous active-low reset empties the pipeline and the output side.
// when out_ch stalls, one more word drops into a skid register and input is
// still taken; only with that register full does the whole pipeline freeze
// and in_ch.ready go low, so nothing is lost or repeated.
module cartesian_to_spherical #(
  parameter int COORD_BITS = c2s_pkg::COORD_BITS_DEF,
  parameter int ANGLE_BITS = c2s_pkg::ANGLE_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  c2s_in_if.sink   in_ch,
  c2s_out_if.source out_ch
);
  import c2s_pkg::*;

  localparam int CB       = COORD_BITS;
  localparam int AB       = ANGLE_BITS;
  localparam int CW       = CORDIC_W;
  localparam int PRESCALE = 60 - CB;
  localparam int SQ_W     = 2 * CB;
  localparam int KQ_W     = PRESCALE + 2;
  localparam int ZK_W     = CB + KQ_W;
  localparam int REM_W    = CB + 2;
  localparam int NC       = 2 * CORDIC_ITERS;
  localparam logic [KQ_W-1:0] KQ     = KQ_W'(gain_scaled(PRESCALE));
  localparam logic [AB-1:0]   EL_UP  = AB'(1) << (AB - 2);
  localparam logic [AB-1:0]   EL_DN  = ~EL_UP + 1'b1;

  logic en;
  logic skid_v_r;

  // pipeline moves unless the skid register is occupied
  assign en          = !skid_v_r;
  assign in_ch.ready = en;

  // ---------------- multiply stage ----------------
  logic [CB-1:0]          mx, my, mz;
  logic signed [CW-1:0]   ya, xb;
  logic signed [ZK_W-1:0] zk_prod;

  logic                   m_v_r;
  logic [SQ_W-1:0]        m_sqx_r, m_sqy_r, m_sqz_r;
  logic signed [CW-1:0]   m_a_r, m_b_r, m_zk_r;
  logic                   m_base_r, m_xy0_r, m_z0_r, m_zneg_r;

  always_comb begin
    mx = in_ch.coord_x[CB-1] ? CB'(-in_ch.coord_x) : CB'(in_ch.coord_x);
    my = in_ch.coord_y[CB-1] ? CB'(-in_ch.coord_y) : CB'(in_ch.coord_y);
    mz = in_ch.coord_z[CB-1] ? CB'(-in_ch.coord_z) : CB'(in_ch.coord_z);
    ya = {{(CW-CB){in_ch.coord_y[CB-1]}}, in_ch.coord_y} <<< PRESCALE;
    xb = {{(CW-CB){in_ch.coord_x[CB-1]}}, in_ch.coord_x} <<< PRESCALE;
  end

  assign zk_prod = in_ch.coord_z * $signed(KQ);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
    end else if (en) begin
      m_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_sqx_r <= mx * mx;
      m_sqy_r <= my * my;
      m_sqz_r <= mz * mz;
      // left half-plane: flip the vector and start half a turn round
      if (ya < 0) begin
        m_a_r    <= -ya;
        m_b_r    <= -xb;
        m_base_r <= 1'b1;
      end else begin
        m_a_r    <= ya;
        m_b_r    <= xb;
        m_base_r <= 1'b0;
      end
      m_zk_r   <= {{(CW-ZK_W){zk_prod[ZK_W-1]}}, zk_prod};
      m_xy0_r  <= (in_ch.coord_x == '0) && (in_ch.coord_y == '0);
      m_z0_r   <= (in_ch.coord_z == '0);
      m_zneg_r <= in_ch.coord_z[CB-1];
    end
  end

  // ---------------- sum stage (entry 0) and vectoring stages ----------------
  logic                    p_v_r    [NC+1];
  logic signed [CW-1:0]    p_a_r    [NC+1];
  logic signed [CW-1:0]    p_b_r    [NC+1];
  logic signed [CW-1:0]    p_zk_r   [NC+1];
  logic signed [ACC_W-1:0] p_acc_r  [NC+1];
  logic signed [ACC_W-1:0] p_az_r   [NC+1];
  logic                    p_base_r [NC+1];
  logic                    p_xy0_r  [NC+1];
  logic                    p_z0_r   [NC+1];
  logic                    p_zneg_r [NC+1];
  logic [SQ_W-1:0]         p_rad_r  [NC+1];
  logic [REM_W-1:0]        p_rem_r  [NC+1];
  logic [CB-1:0]           p_root_r [NC+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r[0] <= 1'b0;
    end else if (en) begin
      p_v_r[0] <= m_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_a_r[0]    <= m_a_r;
      p_b_r[0]    <= m_b_r;
      p_zk_r[0]   <= m_zk_r;
      p_acc_r[0]  <= '0;
      p_az_r[0]   <= '0;
      p_base_r[0] <= m_base_r;
      p_xy0_r[0]  <= m_xy0_r;
      p_z0_r[0]   <= m_z0_r;
      p_zneg_r[0] <= m_zneg_r;
      p_rad_r[0]  <= m_sqx_r + m_sqy_r + m_sqz_r;
      p_rem_r[0]  <= '0;
      p_root_r[0] <= '0;
    end
  end

  for (genvar k = 0; k < NC; k++) begin : g_stage
    localparam int IT = k % CORDIC_ITERS;

    logic signed [CW-1:0]    a_in, b_in, da, db, a_nxt, b_nxt;
    logic signed [ACC_W-1:0] acc_in, acc_nxt, az_nxt, step;
    logic                    up;
    logic [SQ_W-1:0]         rad_nxt;
    logic [REM_W-1:0]        rem_t, trial, rem_nxt;
    logic [CB-1:0]           root_nxt;
    logic                    ge;

    always_comb begin
      // second pass starts from the azimuth magnitude and the scaled z
      if (k == CORDIC_ITERS) begin
        a_in   = p_a_r[k];
        b_in   = p_zk_r[k];
        acc_in = '0;
      end else begin
        a_in   = p_a_r[k];
        b_in   = p_b_r[k];
        acc_in = p_acc_r[k];
      end
      da   = a_in >>> IT;
      db   = b_in >>> IT;
      up   = (b_in > 0);
      step = $signed({2'b00, ATAN_TAB[IT]});
      if (up) begin
        a_nxt   = a_in + db;
        b_nxt   = b_in - da;
        acc_nxt = acc_in + step;
      end else begin
        a_nxt   = a_in - db;
        b_nxt   = b_in + da;
        acc_nxt = acc_in - step;
      end
      if (k == CORDIC_ITERS - 1) begin
        az_nxt = acc_nxt + (p_base_r[k] ? HALF_TURN : '0);
      end else begin
        az_nxt = p_az_r[k];
      end

      // square root, one result bit per stage
      rem_t = {p_rem_r[k][CB-1:0], p_rad_r[k][SQ_W-1 -: 2]};
      trial = {p_root_r[k], 2'b01};
      ge    = (rem_t >= trial);
      if (k < CB) begin
        rad_nxt  = p_rad_r[k] << 2;
        rem_nxt  = ge ? rem_t - trial : rem_t;
        root_nxt = {p_root_r[k][CB-2:0], ge};
      end else begin
        rad_nxt  = p_rad_r[k];
        rem_nxt  = p_rem_r[k];
        root_nxt = p_root_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        p_v_r[k+1] <= 1'b0;
      end else if (en) begin
        p_v_r[k+1] <= p_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        p_a_r[k+1]    <= a_nxt;
        p_b_r[k+1]    <= b_nxt;
        p_zk_r[k+1]   <= p_zk_r[k];
        p_acc_r[k+1]  <= acc_nxt;
        p_az_r[k+1]   <= az_nxt;
        p_base_r[k+1] <= p_base_r[k];
        p_xy0_r[k+1]  <= p_xy0_r[k];
        p_z0_r[k+1]   <= p_z0_r[k];
        p_zneg_r[k+1] <= p_zneg_r[k];
        p_rad_r[k+1]  <= rad_nxt;
        p_rem_r[k+1]  <= rem_nxt;
        p_root_r[k+1] <= root_nxt;
      end
    end
  end

  // ---------------- rounding stage ----------------
  logic signed [ACC_W-1:0] el_c;
  logic [31:0]             az32, el32;
  logic [AB-1:0]           az_rnd, el_rnd;
  logic [CB-1:0]           range_nxt;

  always_comb begin
    if (p_acc_r[NC] > QTR_TURN) begin
      el_c = QTR_TURN;
    end else if (p_acc_r[NC] < -QTR_TURN) begin
      el_c = -QTR_TURN;
    end else begin
      el_c = p_acc_r[NC];
    end
    az32 = p_az_r[NC][31:0];
    el32 = el_c[31:0];
    // round half up: remainder above the root means past the midpoint
    range_nxt = p_root_r[NC] + CB'(p_rem_r[NC] > REM_W'(p_root_r[NC]));
  end

  if (AB < 32) begin : g_round
    logic [32:0] az_sum, el_sum;
    assign az_sum = {1'b0, az32} + (33'd1 << (31 - AB));
    assign el_sum = {1'b0, el32} + (33'd1 << (31 - AB));
    assign az_rnd = az_sum[31 -: AB];
    assign el_rnd = el_sum[31 -: AB];
  end else begin : g_full
    assign az_rnd = az32[AB-1:0];
    assign el_rnd = el32[AB-1:0];
  end

  logic          f_v_r;
  logic [CB-1:0] f_range_r;
  logic [AB-1:0] f_az_r, f_el_r;
  logic          f_flag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else if (en) begin
      f_v_r <= p_v_r[NC];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_range_r <= range_nxt;
      if (p_xy0_r[NC]) begin
        // on the vertical axis the angles are exact, and zero at the origin
        f_az_r   <= '0;
        f_flag_r <= p_z0_r[NC];
        if (p_z0_r[NC]) begin
          f_el_r <= '0;
        end else begin
          f_el_r <= p_zneg_r[NC] ? EL_DN : EL_UP;
        end
      end else begin
        f_az_r   <= az_rnd;
        f_el_r   <= el_rnd;
        f_flag_r <= 1'b0;
      end
    end
  end

  // ---------------- output register and skid ----------------
  logic          out_v_r;
  logic [CB-1:0] out_range_r, skid_range_r;
  logic [AB-1:0] out_az_r, out_el_r, skid_az_r, skid_el_r;
  logic          out_flag_r, skid_flag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_ch.ready) begin
      if (skid_v_r) begin
        out_v_r     <= 1'b1;
        skid_v_r    <= 1'b0;
        out_range_r <= skid_range_r;
        out_az_r    <= skid_az_r;
        out_el_r    <= skid_el_r;
        out_flag_r  <= skid_flag_r;
      end else begin
        out_v_r     <= f_v_r;
        out_range_r <= f_range_r;
        out_az_r    <= f_az_r;
        out_el_r    <= f_el_r;
        out_flag_r  <= f_flag_r;
      end
    end else if (f_v_r && !skid_v_r) begin
      // output held: park the next word
      skid_v_r     <= 1'b1;
      skid_range_r <= f_range_r;
      skid_az_r    <= f_az_r;
      skid_el_r    <= f_el_r;
      skid_flag_r  <= f_flag_r;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.slant_range = out_range_r;
  assign out_ch.azimuth     = out_az_r;
  assign out_ch.elevation   = out_el_r;
  assign out_ch.origin_flag = out_flag_r;

endmodule

/* dv/tb.sv */
// tb: self-checking bench for cartesian_to_spherical, with a bit-true range,
// azimuth and elevation predictor and randomised handshake pressure
// depends on c2s_pkg, c2s_in_if, c2s_out_if and the cartesian_to_spherical rtl
module tb;
  import c2s_pkg::*;

  localparam int CW        = COORD_BITS_DEF;
  localparam int AW        = ANGLE_BITS_DEF;
  localparam int N_RANDOM  = 500;
  localparam int STALL_MAX = 3000;
  localparam int DRAIN     = 80;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } point_t;

  typedef struct packed {
    logic        [CW-1:0] rng;
    logic signed [AW-1:0] az;
    logic signed [AW-1:0] el;
    logic                 org;
  } polar_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  c2s_in_if  #(.COORD_BITS(CW)) in_ch ();
  c2s_out_if #(.COORD_BITS(CW), .ANGLE_BITS(AW)) out_ch ();

  cartesian_to_spherical #(.COORD_BITS(CW), .ANGLE_BITS(AW)) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #5 clk = ~clk;

  point_t pending_pts[$];
  polar_t expected_polar[$];
  int     n_flight = 0;
  int     n_sent = 0;
  int     n_bad = 0;
  int     idle_cycles = 0;
  bit     paused = 1'b0;
  bit     pause_done = 1'b0;

  // vectoring pass, angle in 2^32 per turn; a must be non-negative
  function automatic longint vector_rotate(inout longint a, input longint b);
    longint acc;
    longint da;
    longint db;
    acc = 0;
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      da = a >>> i;
      db = b >>> i;
      if (b > 0) begin
        a = a + db;
        b = b - da;
        acc = acc + longint'(ATAN_TAB[i]);
      end else begin
        a = a - db;
        b = b + da;
        acc = acc - longint'(ATAN_TAB[i]);
      end
    end
    return acc;
  endfunction

  function automatic logic [AW-1:0] angle_round(input longint a);
    logic [63:0] v;
    v = {32'd0, a[31:0]};
    v = (v + (64'd1 << (31 - AW))) >> (32 - AW);
    return v[AW-1:0];
  endfunction

  function automatic logic [CW-1:0] range_root(input logic [127:0] n);
    logic [127:0] s;
    logic [127:0] c;
    s = '0;
    for (int b = 55; b >= 0; b--) begin
      c = s | (128'd1 << b);
      if (c * c <= n) s = c;
    end
    if (n > s * s + s) s = s + 1;
    return s[CW-1:0];
  endfunction

  function automatic polar_t polar_of(input point_t p);
    polar_t r;
    longint x;
    longint y;
    longint z;
    longint a;
    longint b;
    longint acc;
    longint kq;
    longint base;
    logic [127:0] sq;
    x = p.x;
    y = p.y;
    z = p.z;
    sq = 128'(x * x) + 128'(y * y) + 128'(z * z);
    r.rng = range_root(sq);
    r.az = '0;
    r.el = '0;
    r.org = 1'b0;
    if (x == 0 && y == 0) begin
      if (z == 0) r.org = 1'b1;
      else if (z > 0) r.el = angle_round(longint'(1) << 30);
      else r.el = angle_round(longint'(3) << 30);
    end else begin
      kq = longint'(gain_scaled(60 - CW));
      a = y <<< (60 - CW);
      b = x <<< (60 - CW);
      base = 0;
      if (a < 0) begin
        a = -a;
        b = -b;
        base = longint'(1) << 31;
      end
      acc = vector_rotate(a, b) + base;
      r.az = angle_round(acc);
      acc = vector_rotate(a, z * kq);
      // elevation overshoot is clipped at a quarter turn
      if (acc > (longint'(1) << 30)) acc = longint'(1) << 30;
      if (acc < -(longint'(1) << 30)) acc = -(longint'(1) << 30);
      r.el = angle_round(acc);
    end
    return r;
  endfunction

  function automatic logic signed [CW-1:0] rand_coord(input int kind);
    logic signed [CW-1:0] v;
    case (kind)
      0: v = $urandom;
      1: v = $signed($urandom_range(2000)) - 1000;
      2: v = 0;
      default: v = $urandom_range(1) ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    endcase
    return v;
  endfunction

  // idle percentages per phase, taken from words sent so far
  function automatic int src_idle_pct();
    if (n_sent < 200) return 20;
    if (n_sent < 400) return 68;
    return 0;
  endfunction

  function automatic int snk_idle_pct();
    if (n_sent < 200) return 68;
    if (n_sent < 400) return 20;
    return 0;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.coord_x <= '0;
      in_ch.coord_y <= '0;
      in_ch.coord_z <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) n_sent <= n_sent + 1;
      if (!pause_done && n_sent == 300 && !paused) begin
        paused <= 1'b1;
        in_ch.valid <= 1'b0;
      end else if (paused) begin
        // wait until every outstanding word has come back
        if (!in_ch.valid && n_flight == 0) begin
          paused <= 1'b0;
          pause_done <= 1'b1;
        end
      end else if (pending_pts.size() > 0 && $urandom_range(99) >= src_idle_pct()) begin
        in_ch.valid <= 1'b1;
        {in_ch.coord_x, in_ch.coord_y, in_ch.coord_z} <= pending_pts.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    polar_t want;
    polar_t got;
    bit acc_in;
    bit acc_out;
    acc_in = rst_n && in_ch.valid && in_ch.ready;
    acc_out = rst_n && out_ch.valid && out_ch.ready;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= snk_idle_pct());
    end
    if (acc_in) expected_polar.push_back(polar_of({in_ch.coord_x, in_ch.coord_y, in_ch.coord_z}));
    if (acc_out) begin
      got = {out_ch.slant_range, out_ch.azimuth, out_ch.elevation, out_ch.origin_flag};
      if (expected_polar.size() == 0) begin
        n_bad = n_bad + 1;
        if (n_bad <= 10) $display("unexpected word: %p", got);
      end else begin
        want = expected_polar.pop_front();
        if (got.rng !== want.rng || got.az !== want.az || got.el !== want.el
            || got.org !== want.org) begin
          n_bad = n_bad + 1;
          if (n_bad <= 10)
            $display({"mismatch: exp rng %0d az %0d el %0d org %0d,",
                      " got rng %0d az %0d el %0d org %0d"},
                     want.rng, want.az, want.el, want.org,
                     got.rng, got.az, got.el, got.org);
        end
      end
    end
    n_flight <= n_flight + int'(acc_in) - int'(acc_out);
    if (acc_in || acc_out || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  // watchdog
  always @(posedge clk) begin
    if (idle_cycles >= STALL_MAX) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    point_t p;
    int kinds [3];
    in_ch.valid = 1'b0;
    in_ch.coord_x = '0;
    in_ch.coord_y = '0;
    in_ch.coord_z = '0;
    out_ch.ready = 1'b0;
    // origin, vertical axis, half turn, axes and extremes
    pending_pts.push_back('{0, 0, 0});
    pending_pts.push_back('{0, 0, 5});
    pending_pts.push_back('{0, 0, -5});
    pending_pts.push_back('{0, 0, 32'sh7fffffff});
    pending_pts.push_back('{0, 0, 32'sh80000000});
    pending_pts.push_back('{0, -7, 0});
    pending_pts.push_back('{0, 32'sh80000000, 3});
    pending_pts.push_back('{1, 0, 0});
    pending_pts.push_back('{-1, 0, 0});
    pending_pts.push_back('{0, 1, 0});
    pending_pts.push_back('{1, 1, 1});
    pending_pts.push_back('{-1, -1, -1});
    pending_pts.push_back('{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff});
    pending_pts.push_back('{32'sh80000000, 32'sh80000000, 32'sh80000000});
    pending_pts.push_back('{32'sh80000000, 32'sh7fffffff, 32'sh80000000});
    pending_pts.push_back('{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff});
    pending_pts.push_back('{32'sh80000000, 0, 0});
    pending_pts.push_back('{0, 32'sh7fffffff, 0});
    pending_pts.push_back('{1, 1, 32'sh7fffffff});
    pending_pts.push_back('{-1, 1, 32'sh80000000});
    pending_pts.push_back('{-3, -4, 12});
    for (int i = 0; i < N_RANDOM; i++) begin
      for (int k = 0; k < 3; k++) begin
        case ($urandom_range(9))
          0, 1, 2, 3, 4: kinds[k] = 0;
          5, 6: kinds[k] = 1;
          7, 8: kinds[k] = 2;
          default: kinds[k] = 3;
        endcase
      end
      p.x = rand_coord(kinds[0]);
      p.y = rand_coord(kinds[1]);
      p.z = rand_coord(kinds[2]);
      pending_pts.push_back(p);
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_pts.size() == 0 && !in_ch.valid && n_flight == 0);
    repeat (DRAIN) @(posedge clk);
    if (n_bad == 0 && expected_polar.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
